FILE: rtl/core/rne_pkg.sv
// package for the roman numeral encoder: widths, ascii letters, symbol tables
// and the microcode program of the sequencer
// no dependencies
package rne_pkg;

  localparam int ValueW = 12;
  localparam int CharW  = 8;
  localparam int RemW   = 14;
  localparam int PcW    = 4;

  localparam logic [ValueW-1:0] MaxValue = ValueW'(3999);

  // decimal weights of the digit positions
  localparam int WeightTh = 1000;
  localparam int WeightHu = 100;
  localparam int WeightTe = 10;

  // ascii letters
  localparam logic [CharW-1:0] ChrI    = 8'h49;
  localparam logic [CharW-1:0] ChrV    = 8'h56;
  localparam logic [CharW-1:0] ChrX    = 8'h58;
  localparam logic [CharW-1:0] ChrL    = 8'h4C;
  localparam logic [CharW-1:0] ChrC    = 8'h43;
  localparam logic [CharW-1:0] ChrD    = 8'h44;
  localparam logic [CharW-1:0] ChrM    = 8'h4D;
  localparam logic [CharW-1:0] ChrNone = 8'h00;

  // digit positions
  localparam logic [1:0] PosOn = 2'd0;
  localparam logic [1:0] PosTe = 2'd1;
  localparam logic [1:0] PosHu = 2'd2;
  localparam logic [1:0] PosTh = 2'd3;

  // program labels
  localparam logic [PcW-1:0] PcWait = 4'd0;
  localparam logic [PcW-1:0] PcDgTh = 4'd1;
  localparam logic [PcW-1:0] PcEmTh = 4'd2;
  localparam logic [PcW-1:0] PcDgHu = 4'd3;
  localparam logic [PcW-1:0] PcEmHu = 4'd4;
  localparam logic [PcW-1:0] PcDgTe = 4'd5;
  localparam logic [PcW-1:0] PcEmTe = 4'd6;
  localparam logic [PcW-1:0] PcDgOn = 4'd7;
  localparam logic [PcW-1:0] PcEmOn = 4'd8;
  localparam logic [PcW-1:0] PcErr  = 4'd9;

  // micro operations
  typedef enum logic [1:0] {
    OP_WAIT,
    OP_DIG,
    OP_EMIT,
    OP_ERR
  } op_e;

  // symbol roles inside one digit
  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_e;

  // one control word
  typedef struct packed {
    op_e            op;
    logic [1:0]     pos;
    logic [PcW-1:0] jmp;
  } uword_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic       load;
    logic       dig;
    logic       adv;
    logic [1:0] pos;
  } ctrl_t;

  // datapath to sequencer status
  typedef struct packed {
    logic             empty;
    logic             final_sym;
    logic             last;
    logic [CharW-1:0] chr;
  } stat_t;

  // microcode program
  function automatic uword_t urom(input logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      PcWait:  w = '{op: OP_WAIT, pos: PosOn, jmp: PcErr};
      PcDgTh:  w = '{op: OP_DIG,  pos: PosTh, jmp: PcEmTh};
      PcEmTh:  w = '{op: OP_EMIT, pos: PosTh, jmp: PcDgHu};
      PcDgHu:  w = '{op: OP_DIG,  pos: PosHu, jmp: PcEmHu};
      PcEmHu:  w = '{op: OP_EMIT, pos: PosHu, jmp: PcDgTe};
      PcDgTe:  w = '{op: OP_DIG,  pos: PosTe, jmp: PcEmTe};
      PcEmTe:  w = '{op: OP_EMIT, pos: PosTe, jmp: PcDgOn};
      PcDgOn:  w = '{op: OP_DIG,  pos: PosOn, jmp: PcEmOn};
      PcEmOn:  w = '{op: OP_EMIT, pos: PosOn, jmp: PcWait};
      PcErr:   w = '{op: OP_ERR,  pos: PosOn, jmp: PcWait};
      default: w = '{op: OP_WAIT, pos: PosOn, jmp: PcWait};
    endcase
    return w;
  endfunction

  // number of symbols a digit expands to
  function automatic logic [2:0] sym_len(input logic [3:0] d);
    logic [2:0] n;
    if (d == 4'd4 || d == 4'd9) begin
      n = 3'd2;
    end else if (d >= 4'd5 && d <= 4'd8) begin
      n = 3'(d - 4'd4);
    end else if (d <= 4'd3) begin
      n = d[2:0];
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  // symbol role at a place inside the digit's expansion
  function automatic sym_e sym_of(input logic [3:0] d, input logic [1:0] idx);
    sym_e s;
    if (d == 4'd4) begin
      s = (idx == 2'd0) ? SYM_ONE : SYM_FIVE;
    end else if (d == 4'd9) begin
      s = (idx == 2'd0) ? SYM_ONE : SYM_TEN;
    end else if (d >= 4'd5) begin
      s = (idx == 2'd0) ? SYM_FIVE : SYM_ONE;
    end else begin
      s = SYM_ONE;
    end
    return s;
  endfunction

  // letter of a symbol role at a digit position
  function automatic logic [CharW-1:0] letter(input logic [1:0] pos, input sym_e s);
    logic [CharW-1:0] c;
    unique case (pos)
      PosTh: c = ChrM;
      PosHu: c = (s == SYM_ONE) ? ChrC : (s == SYM_FIVE) ? ChrD : ChrM;
      PosTe: c = (s == SYM_ONE) ? ChrX : (s == SYM_FIVE) ? ChrL : ChrC;
      default: c = (s == SYM_ONE) ? ChrI : (s == SYM_FIVE) ? ChrV : ChrX;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/rne_datapath.sv
// datapath of the roman numeral encoder: remainder, digit and symbol index
// registers, one-digit-a-step extraction and letter selection; uses rne_pkg
module rne_datapath (
  input  logic                           clk_i,
  input  logic [rne_pkg::ValueW-1:0]     value_i,
  input  rne_pkg::ctrl_t                 ctrl_i,
  output rne_pkg::stat_t                 stat_o
);

  logic [rne_pkg::ValueW-1:0] rem_q, rem_d;
  logic [3:0]                 dig_q, dig_d;
  logic [1:0]                 idx_q, idx_d;

  logic [3:0]                 dg_th, dg_hu, dg_te;
  logic [rne_pkg::RemW-1:0]   sb_th, sb_hu, sb_te;
  logic [rne_pkg::RemW-1:0]   rem_w;
  logic [3:0]                 dig_new;
  logic [rne_pkg::RemW-1:0]   sub_new;
  logic [2:0]                 len;

  // digit of each weight by parallel compares against its multiples
  always_comb begin
    rem_w = {2'b00, rem_q};
    dg_th = '0;
    sb_th = '0;
    dg_hu = '0;
    sb_hu = '0;
    dg_te = '0;
    sb_te = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_w >= rne_pkg::RemW'(k * rne_pkg::WeightTh)) begin
        dg_th = 4'(k);
        sb_th = rne_pkg::RemW'(k * rne_pkg::WeightTh);
      end
      if (rem_w >= rne_pkg::RemW'(k * rne_pkg::WeightHu)) begin
        dg_hu = 4'(k);
        sb_hu = rne_pkg::RemW'(k * rne_pkg::WeightHu);
      end
      if (rem_w >= rne_pkg::RemW'(k * rne_pkg::WeightTe)) begin
        dg_te = 4'(k);
        sb_te = rne_pkg::RemW'(k * rne_pkg::WeightTe);
      end
    end
  end

  // pick the position being extracted
  always_comb begin
    unique case (ctrl_i.pos)
      rne_pkg::PosTh: begin
        dig_new = dg_th;
        sub_new = sb_th;
      end
      rne_pkg::PosHu: begin
        dig_new = dg_hu;
        sub_new = sb_hu;
      end
      rne_pkg::PosTe: begin
        dig_new = dg_te;
        sub_new = sb_te;
      end
      default: begin
        dig_new = rem_q[3:0];
        sub_new = rem_w;
      end
    endcase
  end

  // register updates
  always_comb begin
    rem_d = rem_q;
    dig_d = dig_q;
    idx_d = idx_q;
    if (ctrl_i.load) begin
      rem_d = value_i;
    end else if (ctrl_i.dig) begin
      rem_d = rne_pkg::ValueW'(rem_w - sub_new);
      dig_d = dig_new;
      idx_d = '0;
    end else if (ctrl_i.adv) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dig_q <= dig_d;
    idx_q <= idx_d;
  end

  // status for the sequencer and the current letter
  always_comb begin
    len              = rne_pkg::sym_len(dig_q);
    stat_o.empty     = (len == 3'd0);
    stat_o.final_sym = ({1'b0, idx_q} == 3'(len - 3'd1));
    stat_o.last      = stat_o.final_sym && (rem_q == '0);
    stat_o.chr       = rne_pkg::letter(ctrl_i.pos, rne_pkg::sym_of(dig_q, idx_q));
  end

endmodule

FILE: rtl/core/roman_numeral_encoder_top.sv
// roman numeral encoder: microcode sequencer with output register
// uses rne_pkg and rne_datapath
//
// an item takes an accept step, 4 digit extraction steps and one emit step
// per character, one character per cycle while the output is not stalled
// (at least one emit step per digit position); an out-of-range value takes
// an accept step and an error step. the microcode program order sets this
// sequence. the first character is registered by the emit step of the first
// nonzero digit position; the range error result by the error step.
// reset clears the step counter and the output valid flag; no memory to clear
module roman_numeral_encoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           value_valid_i,
  output logic                           value_ready_o,
  input  logic [rne_pkg::ValueW-1:0]     value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rne_pkg::CharW-1:0]      char_code_o,
  output logic                           last_o,
  output logic                           range_error_o
);

  logic [rne_pkg::PcW-1:0] pc_q, pc_d;
  rne_pkg::uword_t         uw;
  rne_pkg::ctrl_t          ctrl;
  rne_pkg::stat_t          stat;

  logic                      out_valid_q;
  logic [rne_pkg::CharW-1:0] char_q;
  logic                      last_q;
  logic                      err_q;
  logic                      out_free;
  logic                      emit;
  logic                      emit_err;

  assign out_free      = !out_valid_q || out_ready_i;
  assign value_ready_o = (pc_q == rne_pkg::PcWait);

  rne_datapath u_datapath (
    .clk_i   (clk_i),
    .value_i (value_i),
    .ctrl_i  (ctrl),
    .stat_o  (stat)
  );

  // sequencer: fetch control word, decode, next step
  always_comb begin
    uw        = rne_pkg::urom(pc_q);
    pc_d      = pc_q;
    ctrl.load = 1'b0;
    ctrl.dig  = 1'b0;
    ctrl.adv  = 1'b0;
    ctrl.pos  = uw.pos;
    emit      = 1'b0;
    emit_err  = 1'b0;
    unique case (uw.op)
      rne_pkg::OP_WAIT: begin
        if (value_valid_i) begin
          if (value_i > rne_pkg::MaxValue) begin
            pc_d = uw.jmp;
          end else begin
            ctrl.load = 1'b1;
            pc_d      = pc_q + 1'b1;
          end
        end
      end
      rne_pkg::OP_DIG: begin
        ctrl.dig = 1'b1;
        pc_d     = pc_q + 1'b1;
      end
      rne_pkg::OP_EMIT: begin
        if (stat.empty) begin
          pc_d = uw.jmp;
        end else if (out_free) begin
          emit     = 1'b1;
          ctrl.adv = 1'b1;
          if (stat.final_sym) begin
            pc_d = uw.jmp;
          end
        end
      end
      rne_pkg::OP_ERR: begin
        if (out_free) begin
          emit_err = 1'b1;
          pc_d     = uw.jmp;
        end
      end
    endcase
  end

  // step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= rne_pkg::PcWait;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (emit || emit_err) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= stat.chr;
      last_q <= stat.last;
      err_q  <= 1'b0;
    end else if (emit_err) begin
      char_q <= rne_pkg::ChrNone;
      last_q <= 1'b1;
      err_q  <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_q;
  assign last_o        = last_q;
  assign range_error_o = err_q;

endmodule
